@@ design/pogf_pkg.sv @@
package pogf_pkg;

    // Field widths of the item and result beats.
    localparam int ACT_W  = 2;
    localparam int RING_W = 3;
    localparam int ZONE_W = 3;
    localparam int OZ_W   = 3;
    localparam int CONF_W = 8;
    localparam int ZC_W   = 4;

    // Configuration port geometry.
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;
    localparam int IDX_W  = 3;

    // Item action codes.
    localparam logic [ACT_W-1:0] ACT_HIT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FRAME = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_CONF_RISE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CONF_DECAY  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ENTER_TH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_EXIT_TH     = 3'd3;
    localparam logic [IDX_W-1:0] REG_ZONE_COUNT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SECTOR_MASK = 3'd5;

    // Allowed output zone counts.
    localparam logic [ZC_W-1:0] ZONES_4 = 4'd4;
    localparam logic [ZC_W-1:0] ZONES_6 = 4'd6;
    localparam logic [ZC_W-1:0] ZONES_8 = 4'd8;

    localparam logic [CONF_W-1:0] CONF_MAX = 8'd255;

    // Reset values of the registers.
    localparam logic [CONF_W-1:0] RST_CONF_RISE   = 8'd64;
    localparam logic [CONF_W-1:0] RST_CONF_DECAY  = 8'd32;
    localparam logic [CONF_W-1:0] RST_ENTER_TH    = 8'd128;
    localparam logic [CONF_W-1:0] RST_EXIT_TH     = 8'd64;
    localparam logic [7:0]        RST_SECTOR_MASK = 8'd255;

    typedef struct packed {
        logic [CONF_W-1:0] conf_rise;
        logic [CONF_W-1:0] conf_decay;
        logic [CONF_W-1:0] enter_threshold;
        logic [CONF_W-1:0] exit_threshold;
        logic [ZC_W-1:0]   zone_count;
        logic [7:0]        sector_mask;
    } t_cfg;

endpackage

@@ design/pogf_if.sv @@
// Item channel: one beat carries one grid action.
interface pogf_in_if import pogf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [RING_W-1:0] ring;
    logic [ZONE_W-1:0] zone;

    modport source (output valid, output action, output ring, output zone, input ready);
    modport sink   (input valid, input action, input ring, input zone, output ready);
endinterface

// Result channel: one beat per output zone of a frame.
interface pogf_out_if import pogf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OZ_W-1:0]   out_zone;
    logic              found;
    logic [RING_W-1:0] nearest_ring;
    logic              last;

    modport source (output valid, output out_zone, output found, output nearest_ring,
                    output last, input ready);
    modport sink   (input valid, input out_zone, input found, input nearest_ring,
                    input last, output ready);
endinterface

@@ design/pogf_cfg_regs.sv @@
module pogf_cfg_regs import pogf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;
    logic [ZC_W-1:0]  zc_val;
    logic             zc_ok;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign zc_val  = pwdata[ZC_W-1:0];
    assign zc_ok   = (zc_val == ZONES_4) || (zc_val == ZONES_6) || (zc_val == ZONES_8);

    // Register writes; an unsupported zone count is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conf_rise       <= RST_CONF_RISE;
            r_cfg.conf_decay      <= RST_CONF_DECAY;
            r_cfg.enter_threshold <= RST_ENTER_TH;
            r_cfg.exit_threshold  <= RST_EXIT_TH;
            r_cfg.zone_count      <= ZONES_8;
            r_cfg.sector_mask     <= RST_SECTOR_MASK;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CONF_RISE:   r_cfg.conf_rise       <= pwdata[CONF_W-1:0];
                REG_CONF_DECAY:  r_cfg.conf_decay      <= pwdata[CONF_W-1:0];
                REG_ENTER_TH:    r_cfg.enter_threshold <= pwdata[CONF_W-1:0];
                REG_EXIT_TH:     r_cfg.exit_threshold  <= pwdata[CONF_W-1:0];
                REG_ZONE_COUNT: begin
                    if (zc_ok) begin
                        r_cfg.zone_count <= zc_val;
                    end
                end
                REG_SECTOR_MASK: r_cfg.sector_mask     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_idx)
            REG_CONF_RISE:   prdata = CFG_DW'(r_cfg.conf_rise);
            REG_CONF_DECAY:  prdata = CFG_DW'(r_cfg.conf_decay);
            REG_ENTER_TH:    prdata = CFG_DW'(r_cfg.enter_threshold);
            REG_EXIT_TH:     prdata = CFG_DW'(r_cfg.exit_threshold);
            REG_ZONE_COUNT:  prdata = CFG_DW'(r_cfg.zone_count);
            REG_SECTOR_MASK: prdata = CFG_DW'(r_cfg.sector_mask);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/pogf_bin_alu.sv @@
module pogf_bin_alu import pogf_pkg::*; (
    input  t_cfg              i_cfg,
    input  logic [CONF_W-1:0] i_conf,
    input  logic              i_hit,
    input  logic              i_occ,
    output logic [CONF_W-1:0] o_conf,
    output logic              o_occ
);

    logic [CONF_W:0]   sum;
    logic [CONF_W-1:0] rise_val;
    logic [CONF_W-1:0] decay_val;

    // Saturating rise for a marked bin, floored decay for an unmarked one.
    assign sum       = {1'b0, i_conf} + {1'b0, i_cfg.conf_rise};
    assign rise_val  = sum[CONF_W] ? CONF_MAX : sum[CONF_W-1:0];
    assign decay_val = (i_conf > i_cfg.conf_decay) ? (i_conf - i_cfg.conf_decay) : '0;
    assign o_conf    = i_hit ? rise_val : decay_val;

    // Hysteresis on the occupied flag.
    always_comb begin
        if (!i_occ && (o_conf >= i_cfg.enter_threshold)) begin
            o_occ = 1'b1;
        end else if (i_occ && (o_conf <= i_cfg.exit_threshold)) begin
            o_occ = 1'b0;
        end else begin
            o_occ = i_occ;
        end
    end

endmodule

@@ design/polar_occupancy_grid_filter_unit.sv @@
// Hit and clear items leave the block idle, so it stays ready for the next item.
// A frame item sweeps the bins through one shared update unit, a read state and a write
// state per bin, then builds the zone map, then per output zone searches the rings
// from ring zero outward for the nearest occupied one and sends one result beat.
// Each result beat waits in an output register until taken; ready stays low meanwhile.
// Reset (synchronous, active low) restores register defaults and clears the grid at once.
module polar_occupancy_grid_filter_unit import pogf_pkg::*; #(
    parameter int RING_COUNT  = 8,
    parameter int POLAR_ZONES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pogf_in_if.sink           i_item,
    pogf_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int RW   = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int ZW   = (POLAR_ZONES > 1) ? $clog2(POLAR_ZONES) : 1;
    localparam int BINS = RING_COUNT * POLAR_ZONES;
    localparam int AW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int RMW  = $clog2(2 * POLAR_ZONES + 16);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_MAP,
        S_SEARCH,
        S_OUT
    } t_state;

    t_cfg                   cfg;
    t_state                 r_state;
    logic [RW-1:0]          r_ri;
    logic [ZW-1:0]          r_zi;
    logic [AW-1:0]          r_bin;
    logic [RMW-1:0]         r_rm;
    logic [OZ_W-1:0]        r_qm;
    logic [OZ_W-1:0]        r_oz;
    logic [POLAR_ZONES-1:0] r_hit [RING_COUNT];
    logic [POLAR_ZONES-1:0] r_occ [RING_COUNT];
    logic [BINS-1:0]        r_cvld;
    logic [OZ_W-1:0]        r_zmap [POLAR_ZONES];
    logic [CONF_W-1:0]      mem [BINS];
    logic [CONF_W-1:0]      r_rd_data;
    logic                   r_rd_vld;

    logic                   r_out_vld;
    logic [OZ_W-1:0]        r_out_zone;
    logic                   r_out_found;
    logic [RING_W-1:0]      r_out_ring;
    logic                   r_out_last;

    logic                   in_acc;
    logic                   hit_in_grid;
    logic [RW-1:0]          hit_row;
    logic [ZW-1:0]          hit_col;
    logic                   last_ring;
    logic                   last_zone;
    logic [CONF_W-1:0]      conf_old;
    logic [CONF_W-1:0]      n_conf;
    logic                   n_occ;
    logic                   rm_wrap;
    logic                   qm_last;
    logic                   oz_last;
    logic                   zone_en;
    logic [POLAR_ZONES-1:0] zone_sel;
    logic                   row_hit;

    pogf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Shared bin update unit, fed from the registered memory read.
    assign conf_old = r_rd_vld ? r_rd_data : '0;

    pogf_bin_alu u_alu (
        .i_cfg  (cfg),
        .i_conf (conf_old),
        .i_hit  (r_hit[r_ri][r_zi]),
        .i_occ  (r_occ[r_ri][r_zi]),
        .o_conf (n_conf),
        .o_occ  (n_occ)
    );

    // Item decode.
    assign in_acc      = i_item.valid && i_item.ready;
    assign hit_in_grid = (32'(i_item.ring) < RING_COUNT) && (32'(i_item.zone) < POLAR_ZONES);
    assign hit_row     = RW'(i_item.ring);
    assign hit_col     = ZW'(i_item.zone);

    // Sweep and map counters.
    assign last_ring = (r_ri == RW'(RING_COUNT - 1));
    assign last_zone = (r_zi == ZW'(POLAR_ZONES - 1));
    assign rm_wrap   = (r_rm >= RMW'(2 * POLAR_ZONES));
    assign qm_last   = ({1'b0, r_qm} == (cfg.zone_count - 4'd1));
    assign oz_last   = ({1'b0, r_oz} == (cfg.zone_count - 4'd1));
    assign zone_en   = cfg.sector_mask[r_oz];

    // Polar zones that feed the current output zone, checked on one ring row.
    always_comb begin
        for (int iz = 0; iz < POLAR_ZONES; iz++) begin
            zone_sel[iz] = (r_zmap[iz] == r_oz);
        end
    end
    assign row_hit = |(r_occ[r_ri] & zone_sel);

    // Sequencer: frame sweep, zone map build, nearest-ring search, result beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_cvld    <= '0;
            for (int r = 0; r < RING_COUNT; r++) begin
                r_hit[r] <= '0;
                r_occ[r] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_item.action)
                            ACT_HIT: begin
                                if (hit_in_grid) begin
                                    r_hit[hit_row][hit_col] <= 1'b1;
                                end
                            end
                            ACT_FRAME: begin
                                r_ri    <= '0;
                                r_zi    <= '0;
                                r_bin   <= '0;
                                r_state <= S_READ;
                            end
                            ACT_CLEAR: begin
                                r_cvld <= '0;
                                for (int r = 0; r < RING_COUNT; r++) begin
                                    r_hit[r] <= '0;
                                    r_occ[r] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_occ[r_ri][r_zi] <= n_occ;
                    r_hit[r_ri][r_zi] <= 1'b0;
                    r_cvld[r_bin]     <= 1'b1;
                    r_bin             <= r_bin + 1'b1;
                    if (last_zone) begin
                        r_zi <= '0;
                        if (last_ring) begin
                            r_ri    <= '0;
                            r_rm    <= RMW'(POLAR_ZONES);
                            r_qm    <= '0;
                            r_state <= S_MAP;
                        end else begin
                            r_ri    <= r_ri + 1'b1;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_zi    <= r_zi + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_MAP: begin
                    // One subtract per cycle brings the running remainder below 2M.
                    if (rm_wrap) begin
                        r_rm <= r_rm - RMW'(2 * POLAR_ZONES);
                        r_qm <= qm_last ? '0 : (r_qm + 1'b1);
                    end else begin
                        r_zmap[r_zi] <= r_qm;
                        if (last_zone) begin
                            r_oz    <= '0;
                            r_ri    <= '0;
                            r_state <= S_SEARCH;
                        end else begin
                            r_zi <= r_zi + 1'b1;
                            r_rm <= r_rm + RMW'({cfg.zone_count, 1'b0});
                        end
                    end
                end
                S_SEARCH: begin
                    if (!zone_en || row_hit || last_ring) begin
                        r_out_vld   <= 1'b1;
                        r_out_zone  <= r_oz;
                        r_out_found <= zone_en && row_hit;
                        r_out_ring  <= (zone_en && row_hit) ? RING_W'(r_ri) : '0;
                        r_out_last  <= oz_last;
                        r_state     <= S_OUT;
                    end else begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_out_vld <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oz    <= r_oz + 1'b1;
                            r_ri    <= '0;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Confidence memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            mem[r_bin] <= n_conf;
        end
        r_rd_data <= mem[r_bin];
        r_rd_vld  <= r_cvld[r_bin];
    end

    assign i_item.ready       = (r_state == S_IDLE);
    assign o_res.valid        = r_out_vld;
    assign o_res.out_zone     = r_out_zone;
    assign o_res.found        = r_out_found;
    assign o_res.nearest_ring = r_out_ring;
    assign o_res.last         = r_out_last;

    // The last beat of a frame returns the block to accepting items.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && o_res.last |=> i_item.ready)
        else $error("block not ready after last result beat");

    // A zone without a hit reports ring zero.
    a_nf_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.found |-> (o_res.nearest_ring == '0))
        else $error("nearest ring set on a zone without a hit");

    // Reported zones stay inside the configured zone count.
    a_zone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ({1'b0, o_res.out_zone} < cfg.zone_count))
        else $error("output zone beyond zone count");

    // No item is taken while a result beat is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_item.ready)
        else $error("item accepted while result pending");

endmodule

@@ test/pogf_grid_checker.sv @@
// Watches the item, result and register ports, keeps its own copy of the grid
// and the registers, and compares every result beat with the predicted report.
module pogf_grid_checker import pogf_pkg::*; #(
    parameter int RING_COUNT  = 8,
    parameter int POLAR_ZONES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pogf_in_if                i_item,
    pogf_out_if               i_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS = RING_COUNT * POLAR_ZONES;

    typedef struct packed {
        logic [OZ_W-1:0]   out_zone;
        logic              found;
        logic [RING_W-1:0] nearest_ring;
        logic              last;
    } t_zone_report;

    // Predicted grid, registers and the reports still owed by the block.
    logic              hit_mark [BINS];
    logic [CONF_W-1:0] conf_lvl [BINS];
    logic              occ_flag [BINS];
    t_cfg              cfg;
    t_zone_report      report_q [$];
    t_zone_report      want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_grid();
        for (int b = 0; b < BINS; b++) begin
            hit_mark[b] = 1'b0;
            conf_lvl[b] = '0;
            occ_flag[b] = 1'b0;
        end
    endfunction

    // Only the low byte of a write counts; a zone count other than 4, 6 or 8 is dropped.
    function automatic void write_cfg_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        case (idx)
            REG_CONF_RISE:   cfg.conf_rise = val;
            REG_CONF_DECAY:  cfg.conf_decay = val;
            REG_ENTER_TH:    cfg.enter_threshold = val;
            REG_EXIT_TH:     cfg.exit_threshold = val;
            REG_ZONE_COUNT: begin
                if (val[ZC_W-1:0] == ZONES_4 || val[ZC_W-1:0] == ZONES_6 ||
                    val[ZC_W-1:0] == ZONES_8) begin
                    cfg.zone_count = val[ZC_W-1:0];
                end
            end
            REG_SECTOR_MASK: cfg.sector_mask = val;
            default: ;
        endcase
    endfunction

    // Output zone that a polar zone folds into, in exact integer form.
    function automatic int map_to_out_zone(input int iz, input int n);
        return ((2 * iz * n + POLAR_ZONES) / (2 * POLAR_ZONES)) % n;
    endfunction

    // Ages every bin, applies the occupancy hysteresis, then queues one report per zone.
    function automatic void sweep_and_report();
        int           c;
        int           n;
        int           nearest;
        logic         found;
        t_zone_report rep;
        for (int b = 0; b < BINS; b++) begin
            c = conf_lvl[b];
            if (hit_mark[b]) begin
                c = c + cfg.conf_rise;
                if (c > CONF_MAX) c = CONF_MAX;
            end else begin
                c = (c > cfg.conf_decay) ? c - cfg.conf_decay : 0;
            end
            conf_lvl[b] = CONF_W'(c);
            if (!occ_flag[b] && c >= cfg.enter_threshold) begin
                occ_flag[b] = 1'b1;
            end else if (occ_flag[b] && c <= cfg.exit_threshold) begin
                occ_flag[b] = 1'b0;
            end
            hit_mark[b] = 1'b0;
        end
        n = cfg.zone_count;
        for (int oz = 0; oz < n; oz++) begin
            found   = 1'b0;
            nearest = 0;
            if (cfg.sector_mask[oz]) begin
                for (int r = 0; r < RING_COUNT && !found; r++) begin
                    for (int iz = 0; iz < POLAR_ZONES; iz++) begin
                        if (!found && occ_flag[r * POLAR_ZONES + iz] &&
                            map_to_out_zone(iz, n) == oz) begin
                            found   = 1'b1;
                            nearest = r;
                        end
                    end
                end
            end
            rep.out_zone     = OZ_W'(oz);
            rep.found        = found;
            rep.nearest_ring = RING_W'(nearest);
            rep.last         = (oz + 1 == n);
            report_q.push_back(rep);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_grid();
            cfg.conf_rise       = RST_CONF_RISE;
            cfg.conf_decay      = RST_CONF_DECAY;
            cfg.enter_threshold = RST_ENTER_TH;
            cfg.exit_threshold  = RST_EXIT_TH;
            cfg.zone_count      = ZONES_8;
            cfg.sector_mask     = RST_SECTOR_MASK;
            report_q.delete();
            o_pending <= 0;
        end else begin
            // Register writes land at the access edge.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_cfg_reg(i_paddr[CFG_AW-1:2], i_pwdata[7:0]);
            end

            // Each result beat is held against the oldest owed report.
            if (i_res.valid && i_res.ready) begin
                if (report_q.size() == 0) begin
                    $error("result beat for zone %0d with no report pending", i_res.out_zone);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = report_q.pop_front();
                    if (i_res.out_zone !== want.out_zone) begin
                        $error("out_zone: expected %0d, actual %0d",
                               want.out_zone, i_res.out_zone);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_res.found);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.nearest_ring !== want.nearest_ring) begin
                        $error("nearest_ring: expected %0d, actual %0d",
                               want.nearest_ring, i_res.nearest_ring);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_res.last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end

            // Accepted item beats update the predicted grid.
            if (i_item.valid && i_item.ready) begin
                case (i_item.action)
                    ACT_HIT: begin
                        if (i_item.ring < RING_COUNT && i_item.zone < POLAR_ZONES) begin
                            hit_mark[i_item.ring * POLAR_ZONES + i_item.zone] = 1'b1;
                        end
                    end
                    ACT_FRAME: sweep_and_report();
                    ACT_CLEAR: clear_grid();
                    default: ;
                endcase
            end
            o_pending <= report_q.size();
        end
    end

endmodule

@@ test/tb_polar_occupancy_grid_filter_unit.sv @@
module tb_polar_occupancy_grid_filter_unit import pogf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_COUNT      = 8;
    localparam int POLAR_ZONES     = 8;
    localparam int TIMEOUT_CYCLES  = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int ITEM_SETTLE     = 8;
    localparam int FRAME_SETTLE    = 300;
    localparam int PHASE_ITEMS     = 47;
    localparam int PHASES          = 6;

    // The one action code the block must ignore.
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_reports;
    int cycle_count = 0;
    bit idle_en;
    bit hold_off_req;

    pogf_in_if  item_bus ();
    pogf_out_if res_bus ();

    polar_occupancy_grid_filter_unit #(
        .RING_COUNT  (RING_COUNT),
        .POLAR_ZONES (POLAR_ZONES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pogf_grid_checker #(
        .RING_COUNT  (RING_COUNT),
        .POLAR_ZONES (POLAR_ZONES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_bus),
        .i_res        (res_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_reports)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        res_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(40, 80)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offers one item beat, maybe after an idle burst, and returns at its accepting edge.
    task automatic drive_grid_item(input logic [ACT_W-1:0] act, input logic [RING_W-1:0] rg,
                                   input logic [ZONE_W-1:0] zn);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        item_bus.valid  <= 1'b1;
        item_bus.action <= act;
        item_bus.ring   <= rg;
        item_bus.zone   <= zn;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    // Setup then access cycle; the unused upper data bits carry noise.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drains all owed reports, then lets trailing hit or clear beats finish.
    task automatic wait_grid_idle(input int settle);
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Mode 0 and 1 are the two extreme settings; any other mode is random.
    task automatic program_cfg(input int mode);
        logic [ZC_W-1:0] zc_opts [3];
        logic [7:0]      zc_val;
        zc_opts = '{ZONES_4, ZONES_6, ZONES_8};
        case (mode)
            0: begin
                write_reg(REG_CONF_RISE, 8'd255);
                write_reg(REG_CONF_DECAY, 8'd0);
                write_reg(REG_ENTER_TH, 8'd1);
                write_reg(REG_EXIT_TH, 8'd0);
                write_reg(REG_ZONE_COUNT, {4'h0, ZONES_4});
                write_reg(REG_SECTOR_MASK, 8'hFF);
            end
            1: begin
                write_reg(REG_CONF_RISE, 8'd1);
                write_reg(REG_CONF_DECAY, 8'd255);
                write_reg(REG_ENTER_TH, 8'd255);
                write_reg(REG_EXIT_TH, 8'd254);
                write_reg(REG_ZONE_COUNT, {4'hF, ZONES_6});
                write_reg(REG_SECTOR_MASK, 8'h00);
            end
            default: begin
                write_reg(REG_CONF_RISE, 8'($urandom_range(1, 255)));
                write_reg(REG_CONF_DECAY, ($urandom_range(0, 3) == 0) ?
                          8'($urandom_range(0, 255)) : 8'($urandom_range(0, 80)));
                write_reg(REG_ENTER_TH, 8'($urandom_range(1, 255)));
                write_reg(REG_EXIT_TH, 8'($urandom_range(0, 254)));
                // Some zone count writes carry an illegal count and must be dropped.
                if ($urandom_range(0, 3) == 0) begin
                    zc_val = 8'($urandom);
                end else begin
                    zc_val = {4'($urandom), zc_opts[$urandom_range(0, 2)]};
                end
                write_reg(REG_ZONE_COUNT, zc_val);
                write_reg(REG_SECTOR_MASK, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
            end
        endcase
    endtask

    // Mostly repeated hits on a few tracked objects with frames in between,
    // plus stray hits, clears and ignored beats.
    task automatic run_random_phase(input int n_items);
        logic [RING_W-1:0] trk_ring [4];
        logic [ZONE_W-1:0] trk_zone [4];
        int                n_trk;
        int                sent;
        int                roll;
        int                k;
        n_trk = $urandom_range(1, 4);
        for (int t = 0; t < 4; t++) begin
            trk_ring[t] = RING_W'($urandom);
            trk_zone[t] = ZONE_W'($urandom);
        end
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, n_trk - 1);
            if (roll < 68) begin
                drive_grid_item(ACT_HIT, trk_ring[k], trk_zone[k]);
            end else if (roll < 80) begin
                drive_grid_item(ACT_HIT, RING_W'($urandom), ZONE_W'($urandom));
            end else if (roll < 94) begin
                drive_grid_item(ACT_FRAME, RING_W'($urandom), ZONE_W'($urandom));
                // Objects move now and then so that old bins decay and free up.
                if ($urandom_range(0, 4) == 0) begin
                    trk_ring[k] = RING_W'($urandom);
                    trk_zone[k] = ZONE_W'($urandom);
                end
            end else if (roll < 97) begin
                drive_grid_item(ACT_CLEAR, RING_W'($urandom), ZONE_W'($urandom));
            end else begin
                drive_grid_item(ACT_NONE, RING_W'($urandom), ZONE_W'($urandom));
            end
            if (roll < 97) sent++;
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        item_bus.valid  = 1'b0;
        item_bus.action = ACT_HIT;
        item_bus.ring   = '0;
        item_bus.zone   = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        idle_en         = 1'b1;
        hold_off_req    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corner bins, a repeated hit, two frames to reach the enter level.
        drive_grid_item(ACT_HIT, 3'd0, 3'd0);
        drive_grid_item(ACT_HIT, 3'd7, 3'd7);
        drive_grid_item(ACT_HIT, 3'd0, 3'd0);
        drive_grid_item(ACT_HIT, 3'd2, 3'd5);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);
        drive_grid_item(ACT_HIT, 3'd0, 3'd0);
        drive_grid_item(ACT_HIT, 3'd7, 3'd7);
        drive_grid_item(ACT_HIT, 3'd2, 3'd5);
        drive_grid_item(ACT_FRAME, 3'd7, 3'd7);

        // An unused action marks nothing; decay keeps the bins until the exit level.
        drive_grid_item(ACT_NONE, 3'd7, 3'd7);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);

        // A clear wipes a freshly raised bin.
        drive_grid_item(ACT_HIT, 3'd5, 3'd1);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);
        drive_grid_item(ACT_CLEAR, 3'd7, 3'd7);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);
        wait_grid_idle(ITEM_SETTLE);

        // Saturating rise and full decay with thresholds at the top, six zones with 0, 2 and 5 masked.
        write_reg(REG_CONF_RISE, 8'd255);
        write_reg(REG_CONF_DECAY, 8'd255);
        write_reg(REG_ENTER_TH, 8'd255);
        write_reg(REG_EXIT_TH, 8'd254);
        write_reg(REG_ZONE_COUNT, {4'h0, ZONES_6});
        write_reg(REG_SECTOR_MASK, 8'h5A);
        drive_grid_item(ACT_HIT, 3'd7, 3'd0);
        drive_grid_item(ACT_HIT, 3'd3, 3'd4);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);
        drive_grid_item(ACT_FRAME, 3'd0, 3'd0);
        wait_grid_idle(ITEM_SETTLE);

        // Random phases, each under its own settings.
        for (int ph = 0; ph < PHASES; ph++) begin
            program_cfg(ph);
            if (ph == 2) hold_off_req = 1'b1;
            if (ph == PHASES - 1) idle_en = 1'b0;
            run_random_phase(PHASE_ITEMS);
            wait_grid_idle((ph == PHASES - 1) ? FRAME_SETTLE : ITEM_SETTLE);
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
